/* hw/rtl/prefix_mass_spectrum_scorer_macros.svh */
// Assertion macros shared by the scorer RTL.
`ifndef PREFIX_MASS_SPECTRUM_SCORER_MACROS_SVH
`define PREFIX_MASS_SPECTRUM_SCORER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmss assertion failed");

// Next-cycle implication, disabled during reset.
`define PMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmss assertion failed");

`endif

/* hw/rtl/pmss_pkg.sv */
// Package: types, constants and residue mass table for the mass spectrum scorer.
package pmss_pkg;

  localparam int unsigned MAX_MASS_BINS = 4096;
  localparam int unsigned BIN_W         = $clog2(MAX_MASS_BINS);
  localparam int unsigned SCORE_W       = 32;
  localparam int unsigned ENTRY_W       = SCORE_W + 1;
  localparam int unsigned MASS_W        = 13;
  localparam int unsigned ACC_W         = 48;
  localparam int unsigned AA_W          = 8;
  localparam int unsigned LEN_W         = 13;

  localparam logic [MASS_W-1:0] MASS_MAX = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_RESIDUE = 1'b1;

  localparam logic REG_SPECTRUM_LENGTH = 1'b0;

  typedef struct packed {
    logic              vld;
    logic              add;
    logic              last;
    logic [MASS_W-1:0] mass;
    logic              movf;
  } stage_t;

  typedef struct packed {
    logic              vld;
    logic [ACC_W-1:0]  score;
    logic [MASS_W-1:0] mass;
    logic              sat;
  } result_t;

  function automatic logic [AA_W-1:0] aa_mass(input logic [7:0] c);
    logic [AA_W-1:0] m;
    case (c)
      "G": m = 8'd57;
      "A": m = 8'd71;
      "S": m = 8'd87;
      "P": m = 8'd97;
      "V": m = 8'd99;
      "T": m = 8'd101;
      "C": m = 8'd160;
      "I": m = 8'd113;
      "L": m = 8'd113;
      "N": m = 8'd114;
      "D": m = 8'd115;
      "Q": m = 8'd128;
      "K": m = 8'd128;
      "E": m = 8'd129;
      "M": m = 8'd131;
      "H": m = 8'd137;
      "F": m = 8'd147;
      "R": m = 8'd156;
      "Y": m = 8'd163;
      "W": m = 8'd186;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/prefix_mass_spectrum_scorer.sv */
// Top level of the prefix mass spectrum scorer.
//
// Input stream (in_*): one transaction per item. in_tuser = 0 loads one score
// bin (table_index, prefix_score, suffix_score); in_tuser = 1 is a peptide
// residue letter, with in_tlast on the final residue of the peptide.
// Output stream (out_*): one transaction per peptide, carrying the saturated
// Q32.16 score, the final mass, and a saturation flag in out_tuser.
// Config port (cfg_*): APB-style, register 0 = spectrum_length; write only
// while the stream is idle.
// Throughput: one item per cycle while the output is not stalled. The last
// residue passes the stage 1, stage 2 and output registers before its result
// is valid on out_*.
// Reset clears the running mass, the accumulator, flags and spectrum_length;
// the score store is not cleared and must be loaded before it is read.
// When out_tready is low with a result pending, the whole pipeline holds and
// in_tready drops until the result transaction completes.
`include "prefix_mass_spectrum_scorer_macros.svh"

module prefix_mass_spectrum_scorer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] table_index, [43:12] prefix_score, [75:44] suffix_score,
  // [83:76] residue, [87:84] zero
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [47:0] peptide_score, [60:48] final_mass, [63:61] zero
  output logic [63:0] out_tdata,
  // [0] score_saturated
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [pmss_pkg::LEN_W-1:0]   spec_len_r;
  logic                         cfg_wr;

  logic                         adv;
  logic                         s1_vld_r;
  logic                         s1_type_r;
  logic [pmss_pkg::BIN_W-1:0]   s1_idx_r;
  logic [pmss_pkg::SCORE_W-1:0] s1_pre_r;
  logic [pmss_pkg::SCORE_W-1:0] s1_suf_r;
  logic [7:0]                   s1_res_r;
  logic                         s1_last_r;

  logic [pmss_pkg::MASS_W-1:0]  mass_r;
  logic [pmss_pkg::MASS_W-1:0]  mass_nxt;
  logic                         movf_r;
  logic                         movf_nxt;
  logic [pmss_pkg::MASS_W:0]    msum;
  logic [pmss_pkg::MASS_W-1:0]  m;
  logic                         msat;
  logic                         is_res;
  logic                         s1_res_go;
  pmss_pkg::stage_t             s2_r;
  pmss_pkg::stage_t             s2_nxt;

  logic [pmss_pkg::ENTRY_W-1:0] store [pmss_pkg::MAX_MASS_BINS];
  logic [pmss_pkg::ENTRY_W-1:0] rd_r;
  logic [pmss_pkg::ENTRY_W-1:0] entry;

  pmss_pkg::result_t            res;
  logic                         out_vld_r;
  logic [pmss_pkg::ACC_W-1:0]   out_score_r;
  logic [pmss_pkg::MASS_W-1:0]  out_mass_r;
  logic                         out_sat_r;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr[2] == pmss_pkg::REG_SPECTRUM_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == pmss_pkg::REG_SPECTRUM_LENGTH)
                      ? {{(32 - pmss_pkg::LEN_W){1'b0}}, spec_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_len_r <= '0;
    end else if (cfg_wr) begin
      spec_len_r <= cfg_pwdata[pmss_pkg::LEN_W-1:0];
    end
  end

  // stage 1: input register
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s1_type_r <= in_tuser;
      s1_idx_r  <= in_tdata[11:0];
      s1_pre_r  <= in_tdata[43:12];
      s1_suf_r  <= in_tdata[75:44];
      s1_res_r  <= in_tdata[83:76];
      s1_last_r <= in_tlast;
    end
  end

  // stage 2: mass update, store access
  always_comb begin
    is_res    = s1_type_r == pmss_pkg::REQ_RESIDUE;
    s1_res_go = adv && s1_vld_r && is_res;
    msum      = {1'b0, mass_r}
                + {{(pmss_pkg::MASS_W + 1 - pmss_pkg::AA_W){1'b0}}, pmss_pkg::aa_mass(s1_res_r)};
    msat      = msum[pmss_pkg::MASS_W];
    m         = msat ? pmss_pkg::MASS_MAX : msum[pmss_pkg::MASS_W-1:0];
    mass_nxt  = mass_r;
    movf_nxt  = movf_r;
    if (s1_res_go) begin
      mass_nxt = s1_last_r ? '0 : m;
      movf_nxt = s1_last_r ? 1'b0 : (movf_r | msat);
    end
    s2_nxt.vld  = s1_vld_r && is_res;
    s2_nxt.add  = (m < spec_len_r) && (m < pmss_pkg::MASS_W'(pmss_pkg::MAX_MASS_BINS));
    s2_nxt.last = s1_last_r;
    s2_nxt.mass = m;
    s2_nxt.movf = movf_r | msat;
    entry = {s1_pre_r[pmss_pkg::SCORE_W-1], s1_pre_r}
            + {s1_suf_r[pmss_pkg::SCORE_W-1], s1_suf_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= '0;
      movf_r   <= 1'b0;
      s2_r.vld <= 1'b0;
    end else begin
      mass_r <= mass_nxt;
      movf_r <= movf_nxt;
      if (adv) begin
        s2_r <= s2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r && !is_res) begin
      store[s1_idx_r] <= entry;
    end
    if (adv) begin
      rd_r <= store[m[pmss_pkg::BIN_W-1:0]];
    end
  end

  // stage 3: accumulate
  pmss_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s2    (s2_r),
    .rd    (rd_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_score_r <= res.score;
      out_mass_r  <= res.mass;
      out_sat_r   <= res.sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(64 - pmss_pkg::ACC_W - pmss_pkg::MASS_W){1'b0}}, out_mass_r, out_score_r};
  assign out_tuser  = out_sat_r;

  `PMSS_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_vld_r), $past(s2_r.vld && s2_r.last))
  `PMSS_ASSERT_NEXT(a_mass_clear, clk, rst_n, s1_res_go && s1_last_r, mass_r == '0 && !movf_r)
  `PMSS_ASSERT_NOW(a_ready_stall, clk, rst_n, out_vld_r && !out_tready, !in_tready)

endmodule

/* hw/rtl/pmss_accum.sv */
// Saturating Q32.16 score accumulator with per-peptide overflow tracking.
`include "prefix_mass_spectrum_scorer_macros.svh"

module pmss_accum (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  pmss_pkg::stage_t               s2,
  input  logic [pmss_pkg::ENTRY_W-1:0]   rd,
  output pmss_pkg::result_t              res
);

  logic [pmss_pkg::ACC_W-1:0] acc_r;
  logic [pmss_pkg::ACC_W-1:0] acc_nxt;
  logic                       sovf_r;
  logic                       sovf_nxt;
  logic [pmss_pkg::ACC_W:0]   sum;
  logic [pmss_pkg::ACC_W:0]   addend;
  logic                       pos_ovf;
  logic                       neg_ovf;
  logic [pmss_pkg::ACC_W-1:0] score;

  always_comb begin
    addend = s2.add ? {{(pmss_pkg::ACC_W + 1 - pmss_pkg::ENTRY_W){rd[pmss_pkg::ENTRY_W-1]}}, rd}
                    : '0;
    sum     = {acc_r[pmss_pkg::ACC_W-1], acc_r} + addend;
    pos_ovf = !sum[pmss_pkg::ACC_W] && sum[pmss_pkg::ACC_W-1];
    neg_ovf = sum[pmss_pkg::ACC_W] && !sum[pmss_pkg::ACC_W-1];
    if (pos_ovf) begin
      score = pmss_pkg::ACC_MAX;
    end else if (neg_ovf) begin
      score = pmss_pkg::ACC_MIN;
    end else begin
      score = sum[pmss_pkg::ACC_W-1:0];
    end
    acc_nxt  = acc_r;
    sovf_nxt = sovf_r;
    if (adv && s2.vld) begin
      acc_nxt  = s2.last ? '0 : score;
      sovf_nxt = s2.last ? 1'b0 : (sovf_r | pos_ovf | neg_ovf);
    end
    res.vld   = s2.vld && s2.last;
    res.score = score;
    res.mass  = s2.mass;
    res.sat   = s2.movf | sovf_r | pos_ovf | neg_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      sovf_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      sovf_r <= sovf_nxt;
    end
  end

  `PMSS_ASSERT_NEXT(a_acc_clear, clk, rst_n, adv && s2.vld && s2.last, acc_r == '0 && !sovf_r)
  `PMSS_ASSERT_NEXT(a_acc_hold, clk, rst_n, !adv, $stable(acc_r) && $stable(sovf_r))
  `PMSS_ASSERT_NOW(a_sat_flag, clk, rst_n, s2.vld && (s2.movf || sovf_r), res.sat)

endmodule

/* tb/tb_prefix_mass_spectrum_scorer.sv */
// Self-checking testbench for the prefix mass spectrum scorer: stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_prefix_mass_spectrum_scorer;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned FILL_BINS   = 256;
  localparam logic [2:0]  SPAN_ADDR   = 3'(4 * pmss_pkg::REG_SPECTRUM_LENGTH);
  localparam logic signed [48:0] SCORE_HI = (49'sd1 <<< 47) - 49'sd1;
  localparam logic signed [48:0] SCORE_LO = -(49'sd1 <<< 47);
  localparam logic [7:0] LETTERS [20] = '{"G", "A", "S", "P", "V", "T", "C", "I", "L", "N",
                                         "D", "Q", "K", "E", "M", "H", "F", "R", "Y", "W"};

  typedef struct {
    logic              req_type;
    logic [11:0]       table_index;
    logic signed [31:0] prefix_score;
    logic signed [31:0] suffix_score;
    logic [7:0]        residue;
    logic              last;
  } scorer_req_t;

  typedef struct {
    logic [47:0] score;
    logic [12:0] mass;
    logic        sat;
  } peptide_score_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scorer_req_t    req_pending[$];
  peptide_score_t peptide_results_due[$];

  // predictor state
  logic signed [32:0] bin_score [pmss_pkg::MAX_MASS_BINS];
  logic [12:0]        span_len  = '0;
  logic [12:0]        run_mass  = '0;
  logic [47:0]        run_score = '0;
  logic               sat_seen  = 1'b0;

  int unsigned cyc          = 0;
  int unsigned stall_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  int unsigned mismatches   = 0;
  scorer_req_t drv_req;

  prefix_mass_spectrum_scorer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] letter_mass(input logic [7:0] c);
    case (c)
      "G": return 8'd57;
      "A": return 8'd71;
      "S": return 8'd87;
      "P": return 8'd97;
      "V": return 8'd99;
      "T": return 8'd101;
      "C": return 8'd160;
      "I", "L": return 8'd113;
      "N": return 8'd114;
      "D": return 8'd115;
      "Q", "K": return 8'd128;
      "E": return 8'd129;
      "M": return 8'd131;
      "H": return 8'd137;
      "F": return 8'd147;
      "R": return 8'd156;
      "Y": return 8'd163;
      "W": return 8'd186;
      default: return 8'd0;
    endcase
  endfunction

  task automatic score_request(input scorer_req_t r);
    logic [13:0]        m;
    logic signed [48:0] s;
    logic signed [32:0] b;
    peptide_score_t     res;
    if (r.req_type == pmss_pkg::REQ_LOAD) begin
      bin_score[r.table_index] = {r.prefix_score[31], r.prefix_score}
                               + {r.suffix_score[31], r.suffix_score};
    end else begin
      m = {1'b0, run_mass} + 14'(letter_mass(r.residue));
      if (m > {1'b0, pmss_pkg::MASS_MAX}) begin
        m = {1'b0, pmss_pkg::MASS_MAX};
        sat_seen = 1'b1;
      end
      run_mass = m[12:0];
      if (m < {1'b0, span_len} && m < 14'(pmss_pkg::MAX_MASS_BINS)) begin
        b = bin_score[m[11:0]];
        s = {run_score[47], run_score} + {{16{b[32]}}, b};
        if (s > SCORE_HI) begin
          s = SCORE_HI;
          sat_seen = 1'b1;
        end else if (s < SCORE_LO) begin
          s = SCORE_LO;
          sat_seen = 1'b1;
        end
        run_score = s[47:0];
      end
      if (r.last) begin
        res.score = run_score;
        res.mass  = run_mass;
        res.sat   = sat_seen;
        peptide_results_due.push_back(res);
        run_mass  = '0;
        run_score = '0;
        sat_seen  = 1'b0;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        score_request(drv_req);
      end
      if (!in_tvalid || in_tready) begin
        if (req_pending.size() != 0 &&
            ((cyc % 1000) >= 700 || $urandom_range(0, 99) >= 6)) begin
          drv_req = req_pending.pop_front();
          in_tdata  <= {4'b0, drv_req.residue, drv_req.suffix_score, drv_req.prefix_score,
                        drv_req.table_index};
          in_tlast  <= drv_req.last;
          in_tuser  <= drv_req.req_type;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    peptide_score_t exp_res;
    logic           rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid === 1'b1 && out_tready) begin
        results_seen <= results_seen + 1;
        if (peptide_results_due.size() == 0) begin
          $error("result transaction with no expected result pending");
          mismatches++;
        end else begin
          exp_res = peptide_results_due.pop_front();
          if (out_tdata[47:0] !== exp_res.score) begin
            $error("peptide_score: expected %0d, got %0d",
                   $signed(exp_res.score), $signed(out_tdata[47:0]));
            mismatches++;
          end
          if (out_tdata[60:48] !== exp_res.mass) begin
            $error("final_mass: expected %0d, got %0d", exp_res.mass, out_tdata[60:48]);
            mismatches++;
          end
          if (out_tuser !== exp_res.sat) begin
            $error("score_saturated: expected %0d, got %0d", exp_res.sat, out_tuser);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (!hold_done && results_seen == 10) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        rdy = 1'b0;
      end else begin
        rdy = (cyc % 1000) >= 700 || $urandom_range(0, 99) >= 6;
      end
      out_tready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_load(input logic [11:0] idx, input logic [31:0] pre,
                                    input logic [31:0] suf);
    scorer_req_t r;
    r.req_type     = pmss_pkg::REQ_LOAD;
    r.table_index  = idx;
    r.prefix_score = pre;
    r.suffix_score = suf;
    r.residue      = 8'($urandom());
    r.last         = 1'($urandom());
    req_pending.push_back(r);
  endfunction

  function automatic void push_residue(input logic [7:0] letter, input logic last);
    scorer_req_t r;
    r.req_type     = pmss_pkg::REQ_RESIDUE;
    r.table_index  = 12'($urandom());
    r.prefix_score = $urandom();
    r.suffix_score = $urandom();
    r.residue      = letter;
    r.last         = last;
    req_pending.push_back(r);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 99) < 88) return LETTERS[$urandom_range(0, 19)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == SPAN_ADDR) span_len = val[12:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (req_pending.size() != 0 || in_tvalid || peptide_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(input logic [12:0] span, input int unsigned n_items);
    int unsigned queued;
    int unsigned len;
    write_reg(SPAN_ADDR, 32'(span));
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        push_load(12'($urandom()), rand_score(), rand_score());
        queued++;
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          push_load(12'($urandom()), rand_score(), rand_score());
          queued++;
        end
        push_residue(rand_letter(), k == len - 1);
        queued++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low bins; spans never reach past them, so no score added comes from an unwritten bin
    push_load(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int b = 1; b < FILL_BINS - 1; b++) push_load(12'(b), rand_score(), rand_score());
    push_load(12'(FILL_BINS - 1), 32'h8000_0000, 32'h8000_0000);
    drain();

    // directed: every letter, unknown codes at mass zero, a load whose random tlast is ignored
    write_reg(SPAN_ADDR, 32'(FILL_BINS));
    for (int k = 0; k < 20; k++) push_residue(LETTERS[k], k == 19);
    push_residue(8'h00, 1'b0);
    push_residue(8'hFF, 1'b0);
    push_residue("a", 1'b1);
    push_load(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_residue("W", 1'b1);
    drain();

    random_phase(13'(FILL_BINS), 140);
    random_phase(13'd0, 140);
    random_phase(13'd1, 140);
    random_phase(13'($urandom_range(2, FILL_BINS - 1)), 140);
    random_phase(13'(FILL_BINS - 1), 140);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pmss_pkg.sv
hw/rtl/pmss_accum.sv
hw/rtl/prefix_mass_spectrum_scorer.sv
tb/tb_prefix_mass_spectrum_scorer.sv
